>>> hdl/ima9_pkg.sv
`default_nettype none

package ima9_pkg;

  localparam int unsigned STEP_W    = 15;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned PRED_W    = 16;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned NIB_W     = 4;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(88);

  // decoder state carried from one nibble to the next
  typedef struct packed {
    logic signed [PRED_W-1:0] pred;
    logic [IDX_W-1:0]         idx;
  } ima9_state_t;

  // standard ima step table, indexes past the end read the last entry
  function automatic logic [STEP_W-1:0] ima9_step(input logic [IDX_W-1:0] idx);
    logic [STEP_W-1:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // step index adjustment chosen by the low three code bits
  function automatic logic [4:0] ima9_idx_move(input logic [2:0] mag);
    logic [4:0] m;
    case (mag)
      3'd4:    m = 5'd2;
      3'd5:    m = 5'd4;
      3'd6:    m = 5'd7;
      3'd7:    m = 5'd12;
      default: m = 5'b11111;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ima9_nib_dec.sv
`default_nettype none

module ima9_nib_dec
  import ima9_pkg::*;
(
  input  wire ima9_state_t       st_i,
  input  wire logic [NIB_W-1:0]  code_i,
  output ima9_state_t            st_o
);

  logic [STEP_W-1:0]   step;
  logic [STEP_W+1:0]   mag;
  logic [STEP_W+2:0]   diff;
  logic [PRED_W+2:0]   sum;
  logic [4:0]          move;
  logic [IDX_W:0]      idx_sum;
  logic [PRED_W-1:0]   pred_sat;
  logic [IDX_W-1:0]    idx_clamp;

  // difference magnitude from the step and code bits
  always_comb begin
    step = ima9_step(st_i.idx);
    mag  = (STEP_W+2)'(step >> 3);
    if (code_i[0]) begin
      mag = mag + (STEP_W+2)'(step >> 2);
    end
    if (code_i[1]) begin
      mag = mag + (STEP_W+2)'(step >> 1);
    end
    if (code_i[2]) begin
      mag = mag + (STEP_W+2)'(step);
    end
    if (code_i[2:0] == 3'b111) begin
      mag = mag + (STEP_W+2)'(step >> 1);
    end
    diff = code_i[3] ? -{1'b0, mag} : {1'b0, mag};
  end

  // predictor update with saturation
  always_comb begin
    sum = {{3{st_i.pred[PRED_W-1]}}, st_i.pred} + {diff[STEP_W+2], diff};
    if (sum[PRED_W+2] && !(&sum[PRED_W+1:PRED_W-1])) begin
      pred_sat = {1'b1, {(PRED_W-1){1'b0}}};
    end else if (!sum[PRED_W+2] && (|sum[PRED_W+1:PRED_W-1])) begin
      pred_sat = {1'b0, {(PRED_W-1){1'b1}}};
    end else begin
      pred_sat = sum[PRED_W-1:0];
    end
  end

  // step index update, clamped to the table range
  always_comb begin
    move    = ima9_idx_move(code_i[2:0]);
    idx_sum = {1'b0, st_i.idx} + {{(IDX_W-4){move[4]}}, move};
    if (idx_sum[IDX_W]) begin
      idx_clamp = '0;
    end else if (idx_sum[IDX_W-1:0] > IDX_MAX) begin
      idx_clamp = IDX_MAX;
    end else begin
      idx_clamp = idx_sum[IDX_W-1:0];
    end
  end

  assign st_o = {pred_sat, idx_clamp};

endmodule

`default_nettype wire

>>> hdl/ima9_adpcm_decoder_top.sv
`default_nettype none

// 4-bit ima-style adpcm decoder. Each input word carries two codes in
// in_tdata (low nibble decoded first) and a restart flag in in_tuser that
// clears the predictor and step index before the word is decoded. Each
// input word yields one output word with two signed 8-bit samples, the top
// byte of the 16-bit saturating predictor after each nibble. Words pass an
// input register and an output register; both nibble steps are decoded
// combinationally between them, so one word is taken per clock while the
// output is not stalled; a result enters the output register when its
// word leaves the input register. Backpressure on the output holds both
// registers, and in_tready follows out_tready while the pipeline is full.
module ima9_adpcm_decoder_top
  import ima9_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] code_byte
  input  wire logic        in_tuser,   // [0] restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [7:0] first_sample, [15:8] second_sample
);

  logic                 s1_valid_r;
  logic [CODE_W-1:0]    s1_code_r;
  logic                 s1_restart_r;
  ima9_state_t          st_r;
  ima9_state_t          st_nxt;
  logic                 out_valid_r;
  logic [2*SAMPLE_W-1:0] out_data_r;
  logic [2*SAMPLE_W-1:0] out_data_nxt;
  ima9_state_t          st_start;
  ima9_state_t          st_mid;
  logic                 s2_load;
  logic                 in_take;

  // handshake between the two register stages
  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign in_take   = in_tvalid && in_tready;

  // restart clears the state before the first nibble
  always_comb begin
    if (s1_restart_r) begin
      st_start = '0;
    end else begin
      st_start = st_r;
    end
  end

  // two chained nibble steps
  ima9_nib_dec u_nib_lo (
    .st_i   (st_start),
    .code_i (s1_code_r[NIB_W-1:0]),
    .st_o   (st_mid)
  );

  ima9_nib_dec u_nib_hi (
    .st_i   (st_mid),
    .code_i (s1_code_r[CODE_W-1:NIB_W]),
    .st_o   (st_nxt)
  );

  assign out_data_nxt = {st_nxt.pred[PRED_W-1 -: SAMPLE_W],
                         st_mid.pred[PRED_W-1 -: SAMPLE_W]};

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_take) begin
      s1_code_r    <= in_tdata;
      s1_restart_r <= in_tuser;
    end
  end

  // decoder state and output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_load) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (s2_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // step index stays inside the table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.idx <= IDX_MAX)
    else $error("step index out of range");

  // a restart with a zero-step first code yields a silent first sample
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load && s1_restart_r && (s1_code_r[2:0] == 3'b000)
    |=> out_tdata[SAMPLE_W-1:0] == '0)
    else $error("restart did not clear predictor");

  // a waiting input word is not dropped while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_load |=> s1_valid_r && $stable(s1_code_r))
    else $error("input word lost under stall");

  // decoder state only moves when a word passes to the output register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_load |=> $stable(st_r))
    else $error("decoder state changed without a word");

endmodule

`default_nettype wire
